// File: rtl/dcf77_pwd_pkg.sv
// shared types and constants for the dcf77 pulse width decoder
package dcf77_pwd_pkg;

   // fixed field widths
   localparam int unsigned LEN_WIDTH     = 12;
   localparam int unsigned MISS_WIDTH    = 8;
   localparam int unsigned EVENT_WIDTH   = 3;
   localparam int unsigned POS_OUT_WIDTH = 6;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned REQ_WIDTH     = 8;
   localparam int unsigned RSP_WIDTH     = 16;

   typedef logic [EVENT_WIDTH-1:0]   event_type;
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;

   // event codes
   localparam event_type EV_NONE    = 3'd0;
   localparam event_type EV_MINUTE  = 3'd1;
   localparam event_type EV_ZERO    = 3'd2;
   localparam event_type EV_ONE     = 3'd3;
   localparam event_type EV_MISSING = 3'd4;

   // register indexes
   localparam csr_idx_type REG_MISS_LIMIT     = 3'd0;
   localparam csr_idx_type REG_ZERO_MIN_LEN   = 3'd1;
   localparam csr_idx_type REG_ONE_MIN_LEN    = 3'd2;
   localparam csr_idx_type REG_MINUTE_GAP_LEN = 3'd3;
   localparam csr_idx_type REG_LOST_GAP_LEN   = 3'd4;

   // register reset values
   localparam logic [MISS_WIDTH-1:0] MISS_LIMIT_RST     = 8'd5;
   localparam logic [LEN_WIDTH-1:0]  ZERO_MIN_LEN_RST   = 12'd70;
   localparam logic [LEN_WIDTH-1:0]  ONE_MIN_LEN_RST    = 12'd150;
   localparam logic [LEN_WIDTH-1:0]  MINUTE_GAP_LEN_RST = 12'd1700;
   localparam logic [LEN_WIDTH-1:0]  LOST_GAP_LEN_RST   = 12'd3000;

endpackage

// File: rtl/dcf77_pulse_width_decoder.sv
// dcf77 pulse width decoder top level
//
// One receiver sample enters per transfer on the req_ channel (bit 0 of
// req_tdata, 1 = carrier reduced). Every accepted sample yields exactly one
// result on the rsp_ channel: an event code (none, minute mark, zero bit,
// one bit, signal missing), the decoded bit and the frame position written.
// The decoder state (phase, idle, pulse and miss counters, frame position)
// is updated in the cycle the sample is accepted, and the result sits in an
// output register from the next cycle on; the decoder takes one sample
// per cycle while rsp_tready stays high. When the receiver stalls,
// the held result blocks the next sample only if it is still untaken;
// req_tready is high whenever the output register is empty or is being
// emptied in the same cycle. Thresholds are written through the csr_
// channel, which is always ready; unknown indexes are dropped. Reset
// returns all thresholds to their defaults, clears the counters, puts the
// decoder in the idle phase at frame position zero and empties the output.
module dcf77_pulse_width_decoder #(
   parameter int unsigned FRAME_BITS  = 60,
   parameter int unsigned COUNT_WIDTH = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample input
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [dcf77_pwd_pkg::REQ_WIDTH-1:0]      req_tdata,  // [0] sample_level
   // decoded result
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [dcf77_pwd_pkg::RSP_WIDTH-1:0]      rsp_tdata,  // [2:0] event_res,
                                                                // [3] bit_value,
                                                                // [9:4] bit_position
   // register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dcf77_pwd_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [dcf77_pwd_pkg::LEN_WIDTH-1:0]      csr_data
);

   localparam int unsigned POS_WIDTH = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > dcf77_pwd_pkg::LEN_WIDTH) ?
                                       COUNT_WIDTH : dcf77_pwd_pkg::LEN_WIDTH;
   localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(FRAME_BITS - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [dcf77_pwd_pkg::MISS_WIDTH-1:0] MISS_MAX =
      {dcf77_pwd_pkg::MISS_WIDTH{1'b1}};

   // threshold registers
   logic [dcf77_pwd_pkg::MISS_WIDTH-1:0] miss_limit_ff;
   logic [dcf77_pwd_pkg::LEN_WIDTH-1:0]  zero_min_len_ff;
   logic [dcf77_pwd_pkg::LEN_WIDTH-1:0]  one_min_len_ff;
   logic [dcf77_pwd_pkg::LEN_WIDTH-1:0]  minute_gap_len_ff;
   logic [dcf77_pwd_pkg::LEN_WIDTH-1:0]  lost_gap_len_ff;

   // decoder state
   logic                                 in_pulse_ff,    in_pulse_in;
   logic [COUNT_WIDTH-1:0]               idle_ticks_ff,  idle_ticks_in;
   logic [COUNT_WIDTH-1:0]               pulse_ticks_ff, pulse_ticks_in;
   logic [dcf77_pwd_pkg::MISS_WIDTH-1:0] miss_ticks_ff,  miss_ticks_in;
   logic [POS_WIDTH-1:0]                 frame_pos_ff,   frame_pos_in;

   // result register
   logic                                 rsp_valid_ff,   rsp_valid_in;
   dcf77_pwd_pkg::event_type             event_ff,       event_in;
   logic                                 bit_value_ff,   bit_value_in;
   logic [POS_WIDTH-1:0]                 bit_pos_ff,     bit_pos_in;

   logic                                 req_xfer;
   logic                                 sample_level;
   logic [COUNT_WIDTH-1:0]               idle_inc;
   logic [COUNT_WIDTH-1:0]               pulse_inc;
   logic [dcf77_pwd_pkg::MISS_WIDTH-1:0] miss_inc;
   logic [dcf77_pwd_pkg::POS_OUT_WIDTH-1:0] bit_pos_out;

   // handshakes
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_xfer     = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;
   assign sample_level = req_tdata[0];

   // saturating increments
   assign idle_inc  = (idle_ticks_ff == CNT_MAX) ? idle_ticks_ff : idle_ticks_ff + 1'b1;
   assign pulse_inc = (pulse_ticks_ff == CNT_MAX) ? pulse_ticks_ff : pulse_ticks_ff + 1'b1;
   assign miss_inc  = (miss_ticks_ff == MISS_MAX) ? miss_ticks_ff : miss_ticks_ff + 1'b1;

   // next state and result for one sample
   always_comb begin
      in_pulse_in    = in_pulse_ff;
      idle_ticks_in  = idle_ticks_ff;
      pulse_ticks_in = pulse_ticks_ff;
      miss_ticks_in  = miss_ticks_ff;
      frame_pos_in   = frame_pos_ff;
      event_in       = dcf77_pwd_pkg::EV_NONE;
      bit_value_in   = 1'b0;
      bit_pos_in     = '0;
      if (sample_level) begin
         if (!in_pulse_ff) begin
            // pulse starts; a long gap before it is a minute mark
            in_pulse_in = 1'b1;
            if (CMP_WIDTH'(idle_ticks_ff) >= CMP_WIDTH'(minute_gap_len_ff)) begin
               idle_ticks_in = '0;
               frame_pos_in  = '0;
               event_in      = dcf77_pwd_pkg::EV_MINUTE;
            end
         end else begin
            pulse_ticks_in = pulse_inc;
            miss_ticks_in  = '0;
         end
      end else if (!in_pulse_ff) begin
         // idle tick, flag lost signal after a long gap
         idle_ticks_in = idle_inc;
         if (CMP_WIDTH'(idle_inc) >= CMP_WIDTH'(lost_gap_len_ff)) begin
            event_in = dcf77_pwd_pkg::EV_MISSING;
         end
      end else begin
         // low tick inside a pulse
         pulse_ticks_in = pulse_inc;
         miss_ticks_in  = miss_inc;
         if (miss_inc >= miss_limit_ff) begin
            if ((CMP_WIDTH'(pulse_inc) >= CMP_WIDTH'(one_min_len_ff)) ||
                (CMP_WIDTH'(pulse_inc) >= CMP_WIDTH'(zero_min_len_ff))) begin
               bit_value_in  = (CMP_WIDTH'(pulse_inc) >= CMP_WIDTH'(one_min_len_ff));
               event_in      = bit_value_in ? dcf77_pwd_pkg::EV_ONE : dcf77_pwd_pkg::EV_ZERO;
               bit_pos_in    = frame_pos_ff;
               frame_pos_in  = (frame_pos_ff >= POS_LAST) ? '0 : frame_pos_ff + 1'b1;
               idle_ticks_in = '0;
            end
            pulse_ticks_in = '0;
            miss_ticks_in  = '0;
            in_pulse_in    = 1'b0;
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_limit_ff     <= dcf77_pwd_pkg::MISS_LIMIT_RST;
         zero_min_len_ff   <= dcf77_pwd_pkg::ZERO_MIN_LEN_RST;
         one_min_len_ff    <= dcf77_pwd_pkg::ONE_MIN_LEN_RST;
         minute_gap_len_ff <= dcf77_pwd_pkg::MINUTE_GAP_LEN_RST;
         lost_gap_len_ff   <= dcf77_pwd_pkg::LOST_GAP_LEN_RST;
         in_pulse_ff       <= 1'b0;
         idle_ticks_ff     <= '0;
         pulse_ticks_ff    <= '0;
         miss_ticks_ff     <= '0;
         frame_pos_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            in_pulse_ff    <= in_pulse_in;
            idle_ticks_ff  <= idle_ticks_in;
            pulse_ticks_ff <= pulse_ticks_in;
            miss_ticks_ff  <= miss_ticks_in;
            frame_pos_ff   <= frame_pos_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               dcf77_pwd_pkg::REG_MISS_LIMIT: begin
                  miss_limit_ff <= csr_data[dcf77_pwd_pkg::MISS_WIDTH-1:0];
               end
               dcf77_pwd_pkg::REG_ZERO_MIN_LEN:   zero_min_len_ff   <= csr_data;
               dcf77_pwd_pkg::REG_ONE_MIN_LEN:    one_min_len_ff    <= csr_data;
               dcf77_pwd_pkg::REG_MINUTE_GAP_LEN: minute_gap_len_ff <= csr_data;
               dcf77_pwd_pkg::REG_LOST_GAP_LEN:   lost_gap_len_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         event_ff     <= event_in;
         bit_value_ff <= bit_value_in;
         bit_pos_ff   <= bit_pos_in;
      end
   end

   assign bit_pos_out = dcf77_pwd_pkg::POS_OUT_WIDTH'(bit_pos_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {6'b0, bit_pos_out, bit_value_ff, event_ff};

endmodule
